### src/ddo_pkg.sv
//------------------------------------------------------------------------------
// Odometry package
// Shared word types, state encoding and arithmetic constants.
//------------------------------------------------------------------------------
package ddo_pkg;

	localparam int CordicSteps = 16;
	localparam int PosFracBits = 14;
	localparam int CordicN = (CordicSteps > 24) ? 24 : CordicSteps;

	localparam logic [21:0] TicksPerHalfMmQ16 = 22'd1755733;
	localparam logic [22:0] TicksPerCdegQ24 = 23'd7687795;
	localparam logic [26:0] PhasePerTickQ40 = 27'd66652342;
	localparam logic [27:0] HalfMmPerTickQ32 = 28'd160317668;
	localparam logic [25:0] CdegPerTickQ24 = 26'd36613224;
	localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

	// Heading wrap: restoring reduction modulo 36000, one compare per cycle.
	// The reported centidegree magnitude stays below 2^33.
	localparam logic [15:0] HeadingWrap = 16'd36000;
	localparam int WrapSteps = 18;
	localparam logic [32:0] WrapDivTop = 33'd4718592000;

	typedef struct packed {
		logic action;
		logic signed [7:0] left_ticks;
		logic signed [7:0] right_ticks;
		logic signed [15:0] set_x_half_mm;
		logic signed [15:0] set_y_half_mm;
		logic [15:0] set_heading_centideg;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] x_half_mm;
		logic signed [15:0] y_half_mm;
		logic [15:0] heading_centideg;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_PHASE,
		ST_CORDIC,
		ST_TRIG,
		ST_REPORT,
		ST_WRAP,
		ST_DONE
	} state_t;

	// Arctangent table in units of a 2^32 turn.
	function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0: atan_turn = 32'sd536870912;
			5'd1: atan_turn = 32'sd316933406;
			5'd2: atan_turn = 32'sd167458907;
			5'd3: atan_turn = 32'sd85004756;
			5'd4: atan_turn = 32'sd42667331;
			5'd5: atan_turn = 32'sd21354465;
			5'd6: atan_turn = 32'sd10679838;
			5'd7: atan_turn = 32'sd5340245;
			5'd8: atan_turn = 32'sd2670163;
			5'd9: atan_turn = 32'sd1335087;
			5'd10: atan_turn = 32'sd667544;
			5'd11: atan_turn = 32'sd333772;
			5'd12: atan_turn = 32'sd166886;
			5'd13: atan_turn = 32'sd83443;
			5'd14: atan_turn = 32'sd41722;
			5'd15: atan_turn = 32'sd20861;
			5'd16: atan_turn = 32'sd10430;
			5'd17: atan_turn = 32'sd5215;
			5'd18: atan_turn = 32'sd2608;
			5'd19: atan_turn = 32'sd1304;
			5'd20: atan_turn = 32'sd652;
			5'd21: atan_turn = 32'sd326;
			5'd22: atan_turn = 32'sd163;
			5'd23: atan_turn = 32'sd81;
			default: atan_turn = 32'sd0;
		endcase
	endfunction

endpackage

### src/differential_drive_odometry.sv
//------------------------------------------------------------------------------
// Differential drive odometry
// Dead-reckoning pose tracker with a bit-serial multiplier and iterated CORDIC.
//------------------------------------------------------------------------------
//  channel | signals                       | word type
//  in      | in_valid, in_ready, in_data   | ddo_pkg::in_word_t
//  out     | out_valid, out_ready, out_data| ddo_pkg::out_word_t
//
// One word is processed at a time. A shared shift-and-add multiplier takes
// one multiplier bit per cycle for two 9-bit (update) or 22-bit (set)
// position products, a 32-bit phase product and three 32-bit report
// products; between these run CordicN CORDIC rotations and 18 heading wrap
// steps. The next word is taken only once the result has been loaded into
// the result register. A full result register holds the block in its last
// state until the word leaves. Reset sets the pose to zero heading at
// origin.
//------------------------------------------------------------------------------
module differential_drive_odometry (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ddo_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ddo_pkg::out_word_t  out_data
);

	ddo_pkg::state_t state_q, state_d;

	logic signed [31:0] pos_x_q, pos_y_q, head_q;
	logic signed [17:0] cos_q, sin_q;
	ddo_pkg::in_word_t word_q;

	// Serial multiplier: signed multiplicand, unsigned or signed multiplier.
	logic signed [63:0] acc_q;
	logic signed [63:0] mcand_q;
	logic [31:0] mplier_q;
	logic [5:0] bits_q;
	logic msb_neg_q;
	logic [2:0] sub_q;
	logic mul_busy;

	// CORDIC registers.
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [1:0] quad_q;
	logic [4:0] it_q;

	logic signed [15:0] hx_q, hy_q;

	// Heading wrap registers.
	logic [32:0] rem_q, div_q;
	logic neg_q;
	logic signed [63:0] cd_w;
	logic [15:0] head_cd;
	logic load_out;

	assign mul_busy = (bits_q != 6'd0);

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction

	function automatic logic signed [63:0] to_pos(input logic signed [63:0] v);
		if (ddo_pkg::PosFracBits >= 16) to_pos = v <<< (ddo_pkg::PosFracBits - 16);
		else to_pos = v >>> (16 - ddo_pkg::PosFracBits);
	endfunction

	function automatic logic signed [63:0] trunc_sh(input logic signed [63:0] v,
			input int s);
		logic signed [63:0] t;
		t = v >>> s;
		if (v < 0 && ((v & ((64'sd1 <<< s) - 64'sd1)) != 64'sd0)) t = t + 64'sd1;
		trunc_sh = t;
	endfunction

	function automatic logic signed [17:0] clampu(input logic signed [31:0] v);
		if (v > 32'sd65536) clampu = 18'sd65536;
		else if (v < -32'sd65536) clampu = -18'sd65536;
		else clampu = v[17:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) sat16 = 16'sh7fff;
		else if (v < -64'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	// Centidegrees of the heading product, and the wrapped heading.
	assign cd_w = trunc_sh(acc_q, 24);
	assign head_cd = (neg_q && rem_q != 33'd0) ?
		16'(ddo_pkg::HeadingWrap - rem_q[15:0]) : rem_q[15:0];
	assign load_out = (state_q == ddo_pkg::ST_DONE) && (!out_valid || out_ready);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ddo_pkg::ST_IDLE: if (in_valid && in_ready) state_d = ddo_pkg::ST_POS;
			ddo_pkg::ST_POS: if (!mul_busy && sub_q == 3'd2) state_d = ddo_pkg::ST_PHASE;
			ddo_pkg::ST_PHASE: if (!mul_busy && sub_q == 3'd1) state_d = ddo_pkg::ST_CORDIC;
			ddo_pkg::ST_CORDIC: if (it_q == 5'(ddo_pkg::CordicN)) state_d = ddo_pkg::ST_TRIG;
			ddo_pkg::ST_TRIG: state_d = ddo_pkg::ST_REPORT;
			ddo_pkg::ST_REPORT: if (!mul_busy && sub_q == 3'd3) state_d = ddo_pkg::ST_WRAP;
			ddo_pkg::ST_WRAP:
				if (it_q == 5'(ddo_pkg::WrapSteps - 1)) state_d = ddo_pkg::ST_DONE;
			ddo_pkg::ST_DONE: if (!out_valid || out_ready) state_d = ddo_pkg::ST_IDLE;
			default: state_d = ddo_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ddo_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ddo_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath and serial arithmetic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q <= '0;
			cos_q <= 18'sd65536;
			sin_q <= '0;
			bits_q <= '0;
			sub_q <= '0;
			it_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			if (mul_busy) begin
				// One multiplier bit per cycle; the top bit weighs negative if signed.
				if (mplier_q[0]) begin
					if (bits_q == 6'd1 && msb_neg_q) acc_q <= acc_q - mcand_q;
					else acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				bits_q <= bits_q - 6'd1;
			end else begin
				case (state_q)
					ddo_pkg::ST_IDLE: begin
						if (in_valid) begin
							word_q <= in_data;
							sub_q <= '0;
						end
					end
					ddo_pkg::ST_POS: begin
						case (sub_q)
							3'd0: begin
								acc_q <= '0;
								msb_neg_q <= !word_q.action;
								if (!word_q.action) begin
									mcand_q <= 64'(cos_q);
									mplier_q <= 32'(9'(word_q.left_ticks) - 9'(word_q.right_ticks));
									bits_q <= 6'd9;
									head_q <= head_q - 32'(word_q.left_ticks)
										- 32'(word_q.right_ticks);
								end else begin
									mcand_q <= 64'(word_q.set_x_half_mm);
									mplier_q <= 32'(ddo_pkg::TicksPerHalfMmQ16);
									bits_q <= 6'd22;
								end
								sub_q <= 3'd1;
							end
							3'd1: begin
								if (!word_q.action) pos_x_q <= sat32(64'(pos_x_q) + to_pos(acc_q));
								else pos_x_q <= sat32(to_pos(acc_q));
								acc_q <= '0;
								if (!word_q.action) begin
									mcand_q <= 64'(sin_q);
									mplier_q <= 32'(9'(word_q.left_ticks) - 9'(word_q.right_ticks));
									bits_q <= 6'd9;
								end else begin
									mcand_q <= 64'(word_q.set_y_half_mm);
									mplier_q <= 32'(ddo_pkg::TicksPerHalfMmQ16);
									bits_q <= 6'd22;
								end
								sub_q <= 3'd2;
							end
							default: begin
								if (!word_q.action) pos_y_q <= sat32(64'(pos_y_q) + to_pos(acc_q));
								else pos_y_q <= sat32(to_pos(acc_q));
								// Set heading: unsigned centidegree times a constant.
								if (word_q.action)
									head_q <= 32'((40'(word_q.set_heading_centideg)
										* 40'(ddo_pkg::TicksPerCdegQ24)) >> 24);
								sub_q <= 3'd0;
							end
						endcase
					end
					ddo_pkg::ST_PHASE: begin
						if (sub_q == 3'd0) begin
							acc_q <= '0;
							mcand_q <= 64'(ddo_pkg::PhasePerTickQ40);
							mplier_q <= head_q;
							msb_neg_q <= 1'b1;
							bits_q <= 6'd32;
							sub_q <= 3'd1;
						end else begin
							quad_q <= 2'((acc_q[39:8] + 32'h2000_0000) >> 30);
							cz_q <= acc_q[39:8]
								- {2'((acc_q[39:8] + 32'h2000_0000) >> 30), 30'd0};
							cx_q <= ddo_pkg::CordicGainQ30;
							cy_q <= '0;
							it_q <= '0;
							sub_q <= 3'd0;
						end
					end
					ddo_pkg::ST_CORDIC: begin
						if (it_q != 5'(ddo_pkg::CordicN)) begin
							if (!cz_q[31]) begin
								cx_q <= cx_q - (cy_q >>> it_q);
								cy_q <= cy_q + (cx_q >>> it_q);
								cz_q <= cz_q - ddo_pkg::atan_turn(it_q);
							end else begin
								cx_q <= cx_q + (cy_q >>> it_q);
								cy_q <= cy_q - (cx_q >>> it_q);
								cz_q <= cz_q + ddo_pkg::atan_turn(it_q);
							end
							it_q <= it_q + 5'd1;
						end
					end
					ddo_pkg::ST_TRIG: begin
						logic signed [31:0] c, s;
						c = (cx_q + 32'sd8192) >>> 14;
						s = (cy_q + 32'sd8192) >>> 14;
						case (quad_q)
							2'd0: begin cos_q <= clampu(c); sin_q <= clampu(s); end
							2'd1: begin cos_q <= clampu(-s); sin_q <= clampu(c); end
							2'd2: begin cos_q <= clampu(-c); sin_q <= clampu(-s); end
							default: begin cos_q <= clampu(s); sin_q <= clampu(-c); end
						endcase
						sub_q <= 3'd0;
					end
					ddo_pkg::ST_REPORT: begin
						case (sub_q)
							3'd0: begin
								acc_q <= '0;
								msb_neg_q <= 1'b1;
								bits_q <= 6'd32;
								mcand_q <= 64'(ddo_pkg::HalfMmPerTickQ32);
								mplier_q <= pos_x_q;
								sub_q <= 3'd1;
							end
							3'd1: begin
								hx_q <= sat16(trunc_sh(acc_q, 32 + ddo_pkg::PosFracBits));
								acc_q <= '0;
								msb_neg_q <= 1'b1;
								bits_q <= 6'd32;
								mcand_q <= 64'(ddo_pkg::HalfMmPerTickQ32);
								mplier_q <= pos_y_q;
								sub_q <= 3'd2;
							end
							3'd2: begin
								hy_q <= sat16(trunc_sh(acc_q, 32 + ddo_pkg::PosFracBits));
								acc_q <= '0;
								msb_neg_q <= 1'b1;
								bits_q <= 6'd32;
								mcand_q <= 64'(ddo_pkg::CdegPerTickQ24);
								mplier_q <= head_q;
								sub_q <= 3'd3;
							end
							default: begin
								// Start the wrap on the heading magnitude.
								neg_q <= cd_w[63];
								rem_q <= cd_w[63] ? 33'(-cd_w) : 33'(cd_w);
								div_q <= ddo_pkg::WrapDivTop;
								it_q <= '0;
							end
						endcase
					end
					ddo_pkg::ST_WRAP: begin
						// One restoring compare and subtract per cycle.
						if (rem_q >= div_q) rem_q <= rem_q - div_q;
						div_q <= div_q >> 1;
						it_q <= it_q + 5'd1;
					end
					ddo_pkg::ST_DONE: begin
						if (load_out) begin
							out_data.x_half_mm <= hx_q;
							out_data.y_half_mm <= hy_q;
							out_data.heading_centideg <= head_cd;
							sub_q <= 3'd0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Assertions.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ddo_pkg::ST_IDLE)) else $error("ready outside idle");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cos_q <= 18'sd65536 && cos_q >= -18'sd65536)) else $error("cos out of range");
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.heading_centideg < 16'd36000)) else $error("heading range");

endmodule
